/* hw/rtl/csre_pkg.sv */
// shared types, constants and arithmetic helpers for the column swap and rotate engine
`default_nettype none
package csre_pkg;

	// default sizing
	localparam int unsigned MAX_ROWS_DEF     = 64;
	localparam int unsigned MAX_COLS_DEF     = 64;
	localparam int unsigned NUM_MATRICES_DEF = 2;
	localparam int unsigned CORDIC_STEPS_DEF = 20;

	localparam int unsigned COEF_W  = 24;
	localparam int unsigned TRIG_W  = 32;
	localparam int unsigned PROD_W  = COEF_W + TRIG_W;
	localparam int unsigned COUNT_W = 7;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;
	localparam logic [COUNT_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [COUNT_W-1:0] COLS_RESET = 7'd64;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_SAT   = 2'd2;

	// cordic constants in q.30
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_READ   = 2'd1,
		REQ_SWAP   = 2'd2,
		REQ_ROTATE = 2'd3
	} csre_req_t;

	typedef struct packed {
		csre_req_t          req_type;
		logic               matrix_sel;
		logic [5:0]         row_index;
		logic [5:0]         col_a;
		logic [5:0]         col_b;
		logic signed [23:0] write_value;
		logic signed [15:0] angle;
	} csre_in_t;

	typedef struct packed {
		logic signed [23:0] read_value;
		logic [1:0]         status;
	} csre_out_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} csre_trig_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] value;
		logic                     sat;
	} csre_rs_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_SWA,
		S_SWB,
		S_CWAIT,
		S_MUL,
		S_WRA,
		S_MUL2,
		S_WRB,
		S_FIN
	} csre_state_t;

	// atan(2^-i) in q.30, truncated
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] r;
		case (i)
			0:       r = 30'd843314856;
			1:       r = 30'd497837829;
			2:       r = 30'd263043836;
			3:       r = 30'd133525158;
			4:       r = 30'd67021686;
			5:       r = 30'd33543515;
			6:       r = 30'd16775850;
			7:       r = 30'd8388437;
			8:       r = 30'd4194282;
			9:       r = 30'd2097149;
			10:      r = 30'd1048575;
			11:      r = 30'd524287;
			12:      r = 30'd262143;
			13:      r = 30'd131071;
			14:      r = 30'd65535;
			15:      r = 30'd32767;
			16:      r = 30'd16383;
			17:      r = 30'd8191;
			18:      r = 30'd4095;
			19:      r = 30'd2047;
			20:      r = 30'd1023;
			21:      r = 30'd511;
			22:      r = 30'd255;
			23:      r = 30'd127;
			24:      r = 30'd63;
			25:      r = 30'd31;
			26:      r = 30'd15;
			27:      r = 30'd7;
			28:      r = 30'd3;
			29:      r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// round half up at bit 30, then clip to q4.20
	function automatic csre_rs_t round_sat(input logic signed [PROD_W:0] acc);
		logic signed [PROD_W+1:0] t;
		logic signed [27:0]       v;
		csre_rs_t                 r;
		t = {acc[PROD_W], acc} + 58'sd536870912;
		v = t[PROD_W+1:30];
		if (v > 28'sd8388607) begin
			r.value = 24'sh7FFFFF;
			r.sat   = 1'b1;
		end else if (v < -28'sd8388608) begin
			r.value = 24'sh800000;
			r.sat   = 1'b1;
		end else begin
			r.value = v[23:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/csre_ram.sv */
// generic ram: one write port, two read ports, registered read data
`default_nettype none
module csre_ram #(
	parameter int unsigned WIDTH  = 24,
	parameter int unsigned DEPTH  = 8192,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_a,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule
`default_nettype wire

/* hw/rtl/csre_cordic.sv */
// iterative cordic: one micro-rotation per cycle, gives cosine and sine in q.30
`default_nettype none
module csre_cordic #(
	parameter int unsigned STEPS = csre_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [15:0]  angle,
	output logic                     done,
	output csre_pkg::csre_trig_t     trig
);

	localparam int unsigned SW = $clog2(STEPS + 1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic                 neg_q;
	logic [SW-1:0]        step_q;
	logic signed [33:0]   x_q;
	logic signed [33:0]   y_q;
	logic signed [34:0]   z_q;
	csre_pkg::csre_trig_t trig_q;

	logic signed [34:0] z0;
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [34:0] at;
	logic signed [33:0] xr;
	logic signed [33:0] yr;

	always_comb begin
		z0 = {{2{angle[15]}}, angle, 17'd0};
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = {5'd0, csre_pkg::atan_q30(int'(step_q))};
		xr = neg_q ? -x_q : x_q;
		yr = neg_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= csre_pkg::GAIN_Q30;
			y_q <= '0;
			// fold the angle into [-pi/2, pi/2], flip signs at the end
			if (z0 > csre_pkg::HALF_PI_Q30) begin
				z_q   <= z0 - csre_pkg::PI_Q30;
				neg_q <= 1'b1;
			end else if (z0 < -csre_pkg::HALF_PI_Q30) begin
				z_q   <= z0 + csre_pkg::PI_Q30;
				neg_q <= 1'b1;
			end else begin
				z_q   <= z0;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[34]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			trig_q.cos_v <= xr[31:0];
			trig_q.sin_v <= yr[31:0];
		end
	end

	assign done = done_q;
	assign trig = trig_q;

endmodule
`default_nettype wire

/* hw/rtl/column_swap_and_rotate_engine_core.sv */
// top level: request decoding, row walker and read-modify-write of the coefficient ram
`default_nettype none
// Each request returns exactly one result. A write goes straight to the result, a read
// waits for the registered ram data first. A swap walks the rows in use, and a rotation waits
// for the cordic and then walks the rows in use. The cost per row is set by the coefficient
// ram, which has a single write port: every row costs one write per column, and a rotation
// adds a multiply step per row between the read data and the first write (and a second one
// before the second write when both columns are the same). One request is in work at a time;
// a finished result waits in the output register while the next request is taken.
// Entries read before they were ever written return undefined data.
module column_swap_and_rotate_engine_core #(
	parameter int unsigned MAX_ROWS     = csre_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS     = csre_pkg::MAX_COLS_DEF,
	parameter int unsigned NUM_MATRICES = csre_pkg::NUM_MATRICES_DEF,
	parameter int unsigned CORDIC_STEPS = csre_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [csre_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [csre_pkg::COUNT_W-1:0]       cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire csre_pkg::csre_in_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output csre_pkg::csre_out_t                     out_data
);

	localparam int unsigned DEPTH  = NUM_MATRICES * MAX_ROWS * MAX_COLS;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW     = csre_pkg::COUNT_W;
	localparam int unsigned QW     = csre_pkg::COEF_W;
	localparam int unsigned PW     = csre_pkg::PROD_W;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic m, input logic [CW-1:0] r,
			input logic [5:0] c);
		return ADDR_W'((int'(m) * MAX_ROWS + int'(r)) * MAX_COLS + int'(c));
	endfunction

	// configuration
	logic [CW-1:0] rows_cfg_q;
	logic [CW-1:0] cols_cfg_q;
	logic [CW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= csre_pkg::ROWS_RESET;
			cols_cfg_q <= csre_pkg::COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csre_pkg::CFG_ROWS_IN_USE: rows_cfg_q <= cfg_wdata;
				csre_pkg::CFG_COLS_IN_USE: cols_cfg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_cfg_q == '0) begin
			rows_eff = CW'(1);
		end else if (int'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = CW'(MAX_ROWS);
		end else begin
			rows_eff = rows_cfg_q;
		end
		if (cols_cfg_q == '0) begin
			cols_eff = CW'(1);
		end else if (int'(cols_cfg_q) > MAX_COLS) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = cols_cfg_q;
		end
	end

	// state
	csre_pkg::csre_state_t state_q;
	csre_pkg::csre_state_t state_d;

	logic                      req_m_q;
	logic [5:0]                req_ca_q;
	logic [5:0]                req_cb_q;
	logic [CW-1:0]             row_q;
	logic [QW-1:0]             a_q;
	logic signed [QW-1:0]      anew_q;
	logic signed [PW-1:0]      p_ac_q;
	logic signed [PW-1:0]      p_bs_q;
	logic signed [PW-1:0]      p_bc_q;
	logic signed [PW-1:0]      p_as_q;
	logic                      sat_q;
	logic [QW-1:0]             res_rv_q;
	logic [1:0]                res_st_q;
	logic                      out_valid_q;
	csre_pkg::csre_out_t       out_q;

	// request checks
	logic accept;
	logic in_err;
	logic m_bad;
	logic row_bad;
	logic ca_bad;
	logic cb_bad;
	logic is_elem;

	assign in_ready = (state_q == csre_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		m_bad   = int'(in_data.matrix_sel) >= NUM_MATRICES;
		row_bad = {1'b0, in_data.row_index} >= rows_eff;
		ca_bad  = {1'b0, in_data.col_a} >= cols_eff;
		cb_bad  = {1'b0, in_data.col_b} >= cols_eff;
		is_elem = (in_data.req_type == csre_pkg::REQ_WRITE) ||
			(in_data.req_type == csre_pkg::REQ_READ);
		in_err  = m_bad || (is_elem ? (row_bad || ca_bad) : (ca_bad || cb_bad));
	end

	// row walk
	logic [CW-1:0] next_row;
	logic          more_rows;
	logic          same_col;
	logic          slot_free;

	assign next_row  = row_q + CW'(1);
	assign more_rows = next_row < rows_eff;
	assign same_col  = req_ca_q == req_cb_q;
	assign slot_free = !out_valid_q || out_ready;

	// ram and cordic
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [QW-1:0]     ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr_a;
	logic [ADDR_W-1:0] ram_raddr_b;
	logic [QW-1:0]     ram_rdata_a;
	logic [QW-1:0]     ram_rdata_b;
	logic              cordic_start;
	logic              cordic_done;
	csre_pkg::csre_trig_t trig;

	csre_ram #(
		.WIDTH  (QW),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	csre_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (in_data.angle),
		.done   (cordic_done),
		.trig   (trig)
	);

	// rotation arithmetic
	csre_pkg::csre_rs_t new_a;
	csre_pkg::csre_rs_t new_b;
	logic signed [QW-1:0] bc_opnd;

	always_comb begin
		new_a   = csre_pkg::round_sat({p_ac_q[PW-1], p_ac_q} + {p_bs_q[PW-1], p_bs_q});
		new_b   = csre_pkg::round_sat({p_bc_q[PW-1], p_bc_q} - {p_as_q[PW-1], p_as_q});
		// a column rotated with itself takes the freshly written a as its b
		bc_opnd = (state_q == csre_pkg::S_MUL2) ? anew_q : $signed(ram_rdata_b);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			csre_pkg::S_IDLE: begin
				if (accept) begin
					if (in_err) begin
						state_d = csre_pkg::S_FIN;
					end else begin
						case (in_data.req_type)
							csre_pkg::REQ_WRITE:  state_d = csre_pkg::S_FIN;
							csre_pkg::REQ_READ:   state_d = csre_pkg::S_READ;
							csre_pkg::REQ_SWAP:   state_d = csre_pkg::S_SWA;
							csre_pkg::REQ_ROTATE: state_d = csre_pkg::S_CWAIT;
							default:              state_d = csre_pkg::S_FIN;
						endcase
					end
				end
			end
			csre_pkg::S_READ:  state_d = csre_pkg::S_FIN;
			csre_pkg::S_SWA:   state_d = csre_pkg::S_SWB;
			csre_pkg::S_SWB:   state_d = more_rows ? csre_pkg::S_SWA : csre_pkg::S_FIN;
			csre_pkg::S_CWAIT: begin
				if (cordic_done) begin
					state_d = csre_pkg::S_MUL;
				end
			end
			csre_pkg::S_MUL:   state_d = csre_pkg::S_WRA;
			csre_pkg::S_WRA:   state_d = same_col ? csre_pkg::S_MUL2 : csre_pkg::S_WRB;
			csre_pkg::S_MUL2:  state_d = csre_pkg::S_WRB;
			csre_pkg::S_WRB:   state_d = more_rows ? csre_pkg::S_MUL : csre_pkg::S_FIN;
			csre_pkg::S_FIN: begin
				if (slot_free) begin
					state_d = csre_pkg::S_IDLE;
				end
			end
			default: state_d = csre_pkg::S_IDLE;
		endcase
	end

	// ram and cordic control
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = elem_addr(req_m_q, row_q, req_ca_q);
		ram_wdata    = ram_rdata_b;
		ram_re       = 1'b0;
		ram_raddr_a  = elem_addr(req_m_q, next_row, req_ca_q);
		ram_raddr_b  = elem_addr(req_m_q, next_row, req_cb_q);
		cordic_start = 1'b0;
		case (state_q)
			csre_pkg::S_IDLE: begin
				if (accept && !in_err) begin
					if (in_data.req_type == csre_pkg::REQ_WRITE) begin
						ram_we    = 1'b1;
						ram_waddr = elem_addr(in_data.matrix_sel, {1'b0, in_data.row_index},
							in_data.col_a);
						ram_wdata = in_data.write_value;
					end else if (in_data.req_type == csre_pkg::REQ_READ) begin
						ram_re      = 1'b1;
						ram_raddr_a = elem_addr(in_data.matrix_sel, {1'b0, in_data.row_index},
							in_data.col_a);
					end else begin
						// first row goes out at once, data waits in the ram output
						ram_re       = 1'b1;
						ram_raddr_a  = elem_addr(in_data.matrix_sel, '0, in_data.col_a);
						ram_raddr_b  = elem_addr(in_data.matrix_sel, '0, in_data.col_b);
						cordic_start = in_data.req_type == csre_pkg::REQ_ROTATE;
					end
				end
			end
			csre_pkg::S_SWA: begin
				ram_we = 1'b1;
				ram_re = more_rows;
			end
			csre_pkg::S_SWB: begin
				ram_we    = 1'b1;
				ram_waddr = elem_addr(req_m_q, row_q, req_cb_q);
				ram_wdata = a_q;
			end
			csre_pkg::S_WRA: begin
				ram_we    = 1'b1;
				ram_wdata = new_a.value;
				ram_re    = more_rows;
			end
			csre_pkg::S_WRB: begin
				ram_we    = 1'b1;
				ram_waddr = elem_addr(req_m_q, row_q, req_cb_q);
				ram_wdata = new_b.value;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csre_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == csre_pkg::S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			csre_pkg::S_IDLE: begin
				if (accept) begin
					req_m_q  <= in_data.matrix_sel;
					req_ca_q <= in_data.col_a;
					req_cb_q <= in_data.col_b;
					row_q    <= '0;
					sat_q    <= 1'b0;
					res_rv_q <= '0;
					res_st_q <= in_err ? csre_pkg::STAT_RANGE : csre_pkg::STAT_OK;
				end
			end
			csre_pkg::S_READ: res_rv_q <= ram_rdata_a;
			csre_pkg::S_SWA:  a_q <= ram_rdata_a;
			csre_pkg::S_SWB:  row_q <= next_row;
			csre_pkg::S_MUL: begin
				p_ac_q <= $signed(ram_rdata_a) * trig.cos_v;
				p_bs_q <= $signed(ram_rdata_b) * trig.sin_v;
				p_bc_q <= bc_opnd * trig.cos_v;
				p_as_q <= $signed(ram_rdata_a) * trig.sin_v;
			end
			csre_pkg::S_WRA: begin
				anew_q <= new_a.value;
				sat_q  <= sat_q | new_a.sat;
			end
			csre_pkg::S_MUL2: p_bc_q <= bc_opnd * trig.cos_v;
			csre_pkg::S_WRB: begin
				sat_q <= sat_q | new_b.sat;
				row_q <= next_row;
				if (!more_rows) begin
					res_st_q <= (sat_q || new_b.sat) ? csre_pkg::STAT_SAT : csre_pkg::STAT_OK;
				end
			end
			csre_pkg::S_FIN: begin
				if (slot_free) begin
					out_q.read_value <= res_rv_q;
					out_q.status     <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
